>>> rtl/embedded_deformation_blend_macros.svh
// ----------------------------------------------------------------------------
// embedded deformation blend assertion macros
// shared concurrent assertion forms, reset gated, reported by $error
// ----------------------------------------------------------------------------
`ifndef EMBEDDED_DEFORMATION_BLEND_MACROS_SVH
`define EMBEDDED_DEFORMATION_BLEND_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define EDB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define EDB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/edb_pkg.sv
// ----------------------------------------------------------------------------
// edb_pkg
// types, constants and step decoding for the deformation graph vertex blend
// ----------------------------------------------------------------------------
package edb_pkg;

    localparam int TABLE_NODES_DEF = 256;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int WORDS_PER_NODE  = 15;
    localparam int WEIGHT_FRAC     = 16;

    localparam int NODE_W   = 8;
    localparam int WSEL_W   = 4;
    localparam int WORD_W   = 32;
    localparam int WEIGHT_W = 17;
    localparam int ACC_W    = 48;
    localparam int PROD_W   = 64;
    localparam int WIDE_W   = 66;
    localparam int LADDR_W  = 16;

    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 96;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TERM  = 1'b1;

    localparam logic [WSEL_W-1:0] WSEL_POS_X = 4'd9;
    localparam logic [WSEL_W-1:0] WSEL_POS_Y = 4'd10;
    localparam logic [WSEL_W-1:0] WSEL_POS_Z = 4'd11;
    localparam logic [WSEL_W-1:0] WSEL_TRN_X = 4'd12;
    localparam logic [WSEL_W-1:0] WSEL_TRN_Y = 4'd13;
    localparam logic [WSEL_W-1:0] WSEL_TRN_Z = 4'd14;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_LAST = 5'd22;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_G,
        OP_T,
        OP_M,
        OP_Q,
        OP_W
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [1:0]        row;
        logic [1:0]        col;
        logic [WSEL_W-1:0] sel;
    } step_t;

    typedef struct packed {
        logic              latch;
        logic              write;
        logic              step_valid;
        logic [STEP_W-1:0] step;
        logic              emit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic last_term;
    } dp_status_t;

    localparam logic signed [WIDE_W-1:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [WIDE_W-1:0] S32_MIN = -66'sd2147483648;
    localparam logic signed [WIDE_W-1:0] S48_MAX = 66'sd140737488355327;
    localparam logic signed [WIDE_W-1:0] S48_MIN = -66'sd140737488355328;

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < S32_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > S48_MAX) begin
            r = 48'sh7fffffffffff;
        end else if (v < S48_MIN) begin
            r = 48'sh800000000000;
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

    // term schedule: g reads, t reads, matrix reads with mac, q, weight mac
    function automatic step_t decode_step(input logic [STEP_W-1:0] step);
        step_t d;
        d = '{op: OP_NOP, row: 2'd0, col: 2'd0, sel: 4'd0};
        unique case (step)
            5'd0:    d = '{op: OP_G, row: 2'd0, col: 2'd0, sel: WSEL_POS_X};
            5'd1:    d = '{op: OP_G, row: 2'd1, col: 2'd0, sel: WSEL_POS_Y};
            5'd2:    d = '{op: OP_G, row: 2'd2, col: 2'd0, sel: WSEL_POS_Z};
            5'd3:    d = '{op: OP_T, row: 2'd0, col: 2'd0, sel: WSEL_TRN_X};
            5'd4:    d = '{op: OP_T, row: 2'd1, col: 2'd0, sel: WSEL_TRN_Y};
            5'd5:    d = '{op: OP_T, row: 2'd2, col: 2'd0, sel: WSEL_TRN_Z};
            5'd6:    d = '{op: OP_M, row: 2'd0, col: 2'd0, sel: 4'd0};
            5'd7:    d = '{op: OP_M, row: 2'd0, col: 2'd1, sel: 4'd1};
            5'd8:    d = '{op: OP_M, row: 2'd0, col: 2'd2, sel: 4'd2};
            5'd9:    d = '{op: OP_M, row: 2'd1, col: 2'd0, sel: 4'd3};
            5'd10:   d = '{op: OP_M, row: 2'd1, col: 2'd1, sel: 4'd4};
            5'd11:   d = '{op: OP_M, row: 2'd1, col: 2'd2, sel: 4'd5};
            5'd12:   d = '{op: OP_M, row: 2'd2, col: 2'd0, sel: 4'd6};
            5'd13:   d = '{op: OP_M, row: 2'd2, col: 2'd1, sel: 4'd7};
            5'd14:   d = '{op: OP_M, row: 2'd2, col: 2'd2, sel: 4'd8};
            5'd15:   d = '{op: OP_Q, row: 2'd0, col: 2'd0, sel: 4'd0};
            5'd16:   d = '{op: OP_Q, row: 2'd1, col: 2'd0, sel: 4'd0};
            5'd17:   d = '{op: OP_Q, row: 2'd2, col: 2'd0, sel: 4'd0};
            5'd18:   d = '{op: OP_W, row: 2'd0, col: 2'd0, sel: 4'd0};
            5'd19:   d = '{op: OP_W, row: 2'd1, col: 2'd0, sel: 4'd0};
            5'd20:   d = '{op: OP_W, row: 2'd2, col: 2'd0, sel: 4'd0};
            default: d = '{op: OP_NOP, row: 2'd0, col: 2'd0, sel: 4'd0};
        endcase
        return d;
    endfunction

endpackage

>>> rtl/edb_ram.sv
// ----------------------------------------------------------------------------
// edb_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module edb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/edb_datapath.sv
// ----------------------------------------------------------------------------
// edb_datapath
// node table, shared multiplier, accumulators and output register
// ----------------------------------------------------------------------------
`include "embedded_deformation_blend_macros.svh"

module edb_datapath #(
    parameter int TABLE_NODES = edb_pkg::TABLE_NODES_DEF,
    parameter int FRAC_BITS   = edb_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  edb_pkg::dp_cmd_t                    cmd,
    output edb_pkg::dp_status_t                 status,
    input  logic [edb_pkg::NODE_W-1:0]          s_node_index,
    input  logic [edb_pkg::WSEL_W-1:0]          s_word_select,
    input  logic signed [edb_pkg::WORD_W-1:0]   s_word_value,
    input  logic signed [edb_pkg::WORD_W-1:0]   s_pos_x,
    input  logic signed [edb_pkg::WORD_W-1:0]   s_pos_y,
    input  logic signed [edb_pkg::WORD_W-1:0]   s_pos_z,
    input  logic [edb_pkg::WEIGHT_W-1:0]        s_weight,
    input  logic                                s_last_term,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [edb_pkg::M_TDATA_W-1:0]       m_tdata,   // out_x, out_y, out_z
    output logic                                m_tuser    // saturated
);
    import edb_pkg::*;

    localparam int DEPTH   = TABLE_NODES * WORDS_PER_NODE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int RACC_W  = PROD_W - FRAC_BITS + 2;

    // latched term item
    logic [NODE_W-1:0]          node_reg;
    logic                       oor_reg;
    logic signed [WORD_W-1:0]   pos_reg [3];
    logic [WEIGHT_W-1:0]        w_reg;
    logic                       last_reg;

    // step pipeline
    step_t                      dec0;
    step_t                      op1_reg, op2_reg;
    logic                       v1_reg, v2_reg;

    // table access
    logic [LADDR_W-1:0]         rd_addr_w, wr_addr_w;
    logic                       wr_en;
    logic [WORD_W-1:0]          ram_rdata;
    logic signed [WORD_W-1:0]   word;

    // arithmetic state
    logic signed [WORD_W-1:0]   g_reg  [3];
    logic signed [WORD_W-1:0]   d_reg  [3];
    logic signed [WORD_W:0]     gt_reg [3];
    logic signed [WORD_W-1:0]   r_reg  [3];
    logic signed [WORD_W-1:0]   q_reg  [3];
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [RACC_W-1:0]   racc_reg;
    logic signed [ACC_W-1:0]    acc_reg [3];

    logic signed [WORD_W:0]     mul_a, mul_b;
    logic signed [WIDE_W-1:0]   mul_full;
    logic signed [PROD_W-1:0]   msh, wsh;
    logic signed [RACC_W-1:0]   racc_base, racc_next;
    logic signed [ACC_W+1:0]    acc_sum;

    // output side
    logic signed [WORD_W-1:0]   osat [3];
    logic [2:0]                 oclip;
    logic [M_TDATA_W-1:0]       out_data_reg;
    logic                       sat_reg;
    logic                       m_tvalid_reg;

    assign dec0 = decode_step(cmd.step);

    // word address is node * 15 + select
    assign rd_addr_w = ({8'd0, node_reg} << 4) - {8'd0, node_reg}
                       + {12'd0, dec0.sel};
    assign wr_addr_w = ({8'd0, s_node_index} << 4) - {8'd0, s_node_index}
                       + {12'd0, s_word_select};

    assign wr_en = cmd.write
                   && (32'(s_node_index) < 32'(TABLE_NODES))
                   && (32'(s_word_select) < 32'(WORDS_PER_NODE));

    edb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (ADDR_W'(wr_addr_w)),
        .wdata (s_word_value),
        .raddr (ADDR_W'(rd_addr_w)),
        .rdata (ram_rdata)
    );

    // nodes beyond the table act as all-zero nodes
    assign word = oor_reg ? '0 : $signed(ram_rdata);

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            node_reg   <= s_node_index;
            oor_reg    <= !(32'(s_node_index) < 32'(TABLE_NODES));
            pos_reg[0] <= s_pos_x;
            pos_reg[1] <= s_pos_y;
            pos_reg[2] <= s_pos_z;
            w_reg      <= s_weight;
            last_reg   <= s_last_term;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.step_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        op1_reg <= dec0;
        op2_reg <= op1_reg;
    end

    // shared multiplier: matrix by offset, or weight by transformed coordinate
    always_comb begin
        if (op1_reg.op == OP_W) begin
            mul_a = $signed({16'd0, w_reg});
            mul_b = 33'(q_reg[op1_reg.row]);
        end else begin
            mul_a = 33'(word);
            mul_b = 33'(d_reg[op1_reg.col]);
        end
        mul_full = mul_a * mul_b;
    end

    // stage one: table word is valid
    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            unique case (op1_reg.op)
                OP_G: begin
                    g_reg[op1_reg.row] <= word;
                    d_reg[op1_reg.row] <= sat32(66'(pos_reg[op1_reg.row]) - 66'(word));
                end
                OP_T: gt_reg[op1_reg.row] <= 33'(g_reg[op1_reg.row]) + 33'(word);
                OP_M: prod_reg <= mul_full[PROD_W-1:0];
                OP_Q: q_reg[op1_reg.row] <= sat32(66'(r_reg[op1_reg.row])
                                                  + 66'(gt_reg[op1_reg.row]));
                OP_W: prod_reg <= mul_full[PROD_W-1:0];
                default: ;
            endcase
        end
    end

    // stage two: floor shifts and sums
    assign msh       = prod_reg >>> FRAC_BITS;
    assign wsh       = prod_reg >>> WEIGHT_FRAC;
    assign racc_base = (op2_reg.col == 2'd0) ? '0 : racc_reg;
    assign racc_next = racc_base + RACC_W'(msh);
    assign acc_sum   = 50'(acc_reg[op2_reg.row]) + 50'(wsh);

    always_ff @(posedge aclk) begin
        if (v2_reg && op2_reg.op == OP_M) begin
            racc_reg <= racc_next;
            if (op2_reg.col == 2'd2) begin
                r_reg[op2_reg.row] <= sat32(66'(racc_next));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            osat[i]  = sat32(66'(acc_reg[i]));
            oclip[i] = (66'(acc_reg[i]) != 66'(osat[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= '0;
            end
        end else if (cmd.emit) begin
            for (int i = 0; i < 3; i++) begin
                acc_reg[i] <= '0;
            end
        end else if (v2_reg && op2_reg.op == OP_W) begin
            acc_reg[op2_reg.row] <= sat48(66'(acc_sum));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= {osat[2], osat[1], osat[0]};
            sat_reg      <= |oclip;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid         = m_tvalid_reg;
    assign m_tdata          = out_data_reg;
    assign m_tuser          = sat_reg;
    assign status.out_free  = !m_tvalid_reg || m_tready;
    assign status.last_term = last_reg;

    `EDB_ASSERT_NEXT(a_emit_clears, aclk, aresetn, cmd.emit,
        m_tvalid && acc_reg[0] == '0 && acc_reg[1] == '0 && acc_reg[2] == '0,
        "accumulators not cleared on result transfer")
    `EDB_ASSERT_NOW(a_no_write_in_term, aclk, aresetn, cmd.write,
        (!v1_reg || op1_reg.op == OP_NOP) && (!v2_reg || op2_reg.op == OP_NOP),
        "table write while a term is in flight")
    `EDB_ASSERT_NEXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "result changed while waiting for transfer")

endmodule

>>> rtl/edb_ctrl.sv
// ----------------------------------------------------------------------------
// edb_ctrl
// term sequencer: accepts items, steps the datapath schedule, hands off result
// ----------------------------------------------------------------------------
`include "embedded_deformation_blend_macros.svh"

module edb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_mode,
    input  edb_pkg::dp_status_t status,
    output edb_pkg::dp_cmd_t    cmd
);
    import edb_pkg::*;

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_mode == MODE_TERM) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_reg == STEP_LAST) begin
                    state_next = status.last_term ? ST_EMIT : ST_IDLE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready       = (state_reg == ST_IDLE);
        cmd.latch      = (state_reg == ST_IDLE) && s_tvalid && s_mode == MODE_TERM;
        cmd.write      = (state_reg == ST_IDLE) && s_tvalid && s_mode == MODE_WRITE;
        cmd.step_valid = (state_reg == ST_RUN);
        cmd.step       = step_reg;
        cmd.emit       = (state_reg == ST_EMIT) && status.out_free;
    end

    `EDB_ASSERT_NEXT(a_step_advance, aclk, aresetn,
        state_reg == ST_RUN && step_reg != STEP_LAST,
        state_reg == ST_RUN && step_reg == $past(step_reg) + 1'b1,
        "term schedule skipped or stalled a step")
    `EDB_ASSERT_NEXT(a_latch_starts_run, aclk, aresetn, cmd.latch,
        state_reg == ST_RUN && step_reg == '0, "term did not start at step zero")
    `EDB_ASSERT_NOW(a_emit_only_last, aclk, aresetn, state_reg == ST_EMIT,
        status.last_term, "result hand-off for a term not marked last")

endmodule

>>> rtl/embedded_deformation_blend.sv
// ----------------------------------------------------------------------------
// embedded_deformation_blend
// deformation graph vertex blend: sum of w * (R * (p - g) + g + t) per vertex
// ----------------------------------------------------------------------------
// channel  dir  tdata (lsb first)                         tuser      tlast
// s_       in   node_index, word_select, word_value,      mode       last_term
//               pos_x, pos_y, pos_z, weight
// m_       out  out_x, out_y, out_z                       saturated  -
//
// a table write item is written straight into the node table ram
// a term item runs 21 schedule steps through the single table read
// port and the one shared 33x33 multiplier, then drains the pipeline
// the term marked last goes on to load the output register, and holds
// there while the previous result is still waiting on m_tready
// input is taken only in the idle state, never while a finished vertex waits
// reset clears control and accumulators; the node table is not cleared
// ----------------------------------------------------------------------------
module embedded_deformation_blend #(
    parameter int TABLE_NODES = edb_pkg::TABLE_NODES_DEF,
    parameter int FRAC_BITS   = edb_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input item transfer
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // node_index[7:0], word_select[11:8], word_value[43:12], pos_x[75:44],
    // pos_y[107:76], pos_z[139:108], weight[156:140], zero fill
    input  logic [edb_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,   // mode
    input  logic                            s_tlast,   // last_term
    // result transfer
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [edb_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser    // saturated
);
    import edb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: owns the input handshake and the term schedule
    edb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_mode   (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: node table, shared multiplier, accumulators, output register
    edb_datapath #(
        .TABLE_NODES (TABLE_NODES),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_node_index  (s_tdata[7:0]),
        .s_word_select (s_tdata[11:8]),
        .s_word_value  ($signed(s_tdata[43:12])),
        .s_pos_x       ($signed(s_tdata[75:44])),
        .s_pos_y       ($signed(s_tdata[107:76])),
        .s_pos_z       ($signed(s_tdata[139:108])),
        .s_weight      (s_tdata[156:140]),
        .s_last_term   (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule
